>>> hw/rtl/ewce_pkg.sv
// ----------------------------------------------------------------------------
// ewce_pkg
// Shared types, constants and the ln(1+f) table-entry function for the weighted CE unit.
// ----------------------------------------------------------------------------
package ewce_pkg;

  localparam int unsigned MaxClassesDef   = 64;
  localparam int unsigned LogTableBitsDef = 10;

  localparam logic [15:0] Ln2Q16  = 16'd45426;
  localparam logic [29:0] Ln2Q30  = 30'd744261118;
  localparam logic [19:0] LnTopQ16 = 20'd681390;  // 15 * ln2
  localparam logic [23:0] LossMax = 24'hFFFFFF;

  localparam logic [1:0] CfgNumClasses   = 2'd0;
  localparam logic [1:0] CfgUnknownClass = 2'd1;
  localparam logic [1:0] CfgClipEps      = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } div_state_e;

  // One queued item after the front end: clipped values and control.
  typedef struct packed {
    logic [15:0] gt;
    logic [15:0] pred;
    logic        is_unknown;
    logic        close_pix;
    logic        last;
    logic [6:0]  n_cls;
    logic [14:0] floor_w;
  } ewce_item_t;

  // ln(1 + i/2^bits) in Q16 by binary log with repeated squaring.
  function automatic logic [16:0] ln1p_entry(input int unsigned i, input int unsigned bits);
    logic [63:0] m;
    logic [63:0] lg;
    logic [63:0] r;
    m  = (64'd1 << 30) + (64'(i) << (30 - bits));
    lg = '0;
    for (int b = 0; b < 20; b++) begin
      m  = (m * m) >> 30;
      lg = lg << 1;
      if (m >= (64'd1 << 31)) begin
        m     = m >> 1;
        lg[0] = 1'b1;
      end
    end
    r = (lg * 64'(Ln2Q30) + (64'd1 << 33)) >> 34;
    return r[16:0];
  endfunction

endpackage

>>> hw/rtl/ewce_front.sv
// ----------------------------------------------------------------------------
// ewce_front
// Accepts items, clips both probabilities, tracks class position in a pixel.
// ----------------------------------------------------------------------------
module ewce_front #(
  parameter int unsigned MaxClasses = ewce_pkg::MaxClassesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          gt_i,
  input  logic [15:0]          pred_i,
  input  logic                 last_i,
  input  logic [6:0]           num_classes_i,
  input  logic [5:0]           unknown_class_i,
  input  logic [13:0]          clip_eps_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output ewce_pkg::ewce_item_t q_item_o
);

  localparam int unsigned CntW = $clog2(MaxClasses + 1);

  logic [CntW-1:0]  count_q, count_d;
  logic [CntW+6:0]  n_eff;
  logic [15:0]      eps, hi_b, g_c, p_c;
  logic             fire, close_pix;

  // Two-entry queue toward the back end.
  ewce_pkg::ewce_item_t buf_q [2];
  logic [1:0] cnt_q;
  logic       wp_q, rp_q;

  assign in_ready_o = (cnt_q != 2'd2);
  assign fire       = in_valid_i & in_ready_o;

  always_comb begin
    eps  = (clip_eps_i == 14'd0) ? 16'd1 : {2'b00, clip_eps_i};
    hi_b = 16'd32768 - eps;
    g_c  = (gt_i < eps) ? eps : ((gt_i > hi_b) ? hi_b : gt_i);
    p_c  = (pred_i < eps) ? eps : ((pred_i > hi_b) ? hi_b : pred_i);
    if (num_classes_i < 7'd2) n_eff = (CntW+7)'(2);
    else if ({{CntW{1'b0}}, num_classes_i} > (CntW+7)'(MaxClasses)) n_eff = (CntW+7)'(MaxClasses);
    else n_eff = (CntW+7)'(num_classes_i);
    close_pix = ((CntW+7)'(count_q) + (CntW+7)'(1) >= n_eff) | last_i;
    count_d   = close_pix ? '0 : count_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cnt_q   <= '0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
        wp_q    <= ~wp_q;
      end
      if (q_valid_o && q_ready_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, fire} - {1'b0, q_valid_o & q_ready_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      buf_q[wp_q].gt         <= g_c;
      buf_q[wp_q].pred       <= p_c;
      buf_q[wp_q].is_unknown <= ((CntW+7)'(count_q) == (CntW+7)'(unknown_class_i));
      buf_q[wp_q].close_pix  <= close_pix;
      buf_q[wp_q].last       <= last_i;
      buf_q[wp_q].n_cls      <= n_eff[6:0];
      buf_q[wp_q].floor_w    <= {eps[13:0], 1'b0};
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = buf_q[rp_q];

endmodule

>>> hw/rtl/ewce_neglog.sv
// ----------------------------------------------------------------------------
// ewce_neglog
// Combinational -ln(x/32768) in Q16 from leading-one position and table.
// ----------------------------------------------------------------------------
module ewce_neglog #(
  parameter int unsigned LogTableBits = ewce_pkg::LogTableBitsDef
) (
  input  logic [15:0] x_i,
  output logic [19:0] y_o
);

  localparam int unsigned TabN = 1 << LogTableBits;

  logic [16:0] tab [TabN];
  logic [3:0]  k;
  logic [15:0] x, frac;
  logic [LogTableBits+15:0] sh;
  logic [LogTableBits-1:0]  idx;
  logic [19:0] hi;

  always_comb begin
    for (int i = 0; i < TabN; i++) tab[i] = ewce_pkg::ln1p_entry(i, LogTableBits);
  end

  always_comb begin
    x = (x_i == 16'd0) ? 16'd1 : x_i;
    k = 4'd0;
    for (int b = 1; b < 16; b++) if (x[b]) k = 4'(b);
    frac = x - (16'd1 << k);
    sh   = ({{LogTableBits{1'b0}}, frac} << LogTableBits) >> k;
    idx  = sh[LogTableBits-1:0];
    hi   = 20'(5'd15 - {1'b0, k}) * 20'(ewce_pkg::Ln2Q16);
    y_o  = (hi > 20'(tab[idx])) ? hi - 20'(tab[idx]) : 20'd0;
  end

endmodule

>>> hw/rtl/ewce_back.sv
// ----------------------------------------------------------------------------
// ewce_back
// Per-item log products, pixel close, accumulation, and final rounded divide.
// ----------------------------------------------------------------------------
module ewce_back #(
  parameter int unsigned LogTableBits = ewce_pkg::LogTableBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  ewce_pkg::ewce_item_t q_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [23:0]          loss_o,
  output logic                 sat_o
);

  // Stage phases for one item.
  typedef enum logic [2:0] {
    PH_IDLE, PH_PRD, PH_MUL, PH_W, PH_WX, PH_ACC, PH_DIV, PH_OUT
  } ph_e;

  ph_e ph_q, ph_d;

  ewce_pkg::ewce_item_t it_q;
  logic [19:0] nlg, nlp, nlc;
  logic [31:0] ent_q, crs_q;
  logic [15:0] ugt_q;
  logic [35:0] pg_q, pp_q;
  logic [31:0] w_q;
  logic [63:0] prod_q, wt_q;
  logic [47:0] ws_q;
  logic [63:0] rem_q, quo_q;
  logic [6:0]  dcnt_q;
  logic [23:0] loss_q;
  logic        sat_q;
  logic [31:0] ent_n, crs_n, lnc;
  logic [47:0] wm;
  logic [64:0] sum65, rtry;
  logic [48:0] ws49;
  logic [64:0] r2;

  ewce_neglog #(.LogTableBits(LogTableBits)) u_lg (.x_i(it_q.gt), .y_o(nlg));
  ewce_neglog #(.LogTableBits(LogTableBits)) u_lp (.x_i(it_q.pred), .y_o(nlp));
  ewce_neglog #(.LogTableBits(LogTableBits)) u_lc (.x_i({9'd0, it_q.n_cls}), .y_o(nlc));

  assign q_ready_o   = (ph_q == PH_IDLE);
  assign out_valid_o = (ph_q == PH_OUT);
  assign loss_o      = loss_q;
  assign sat_o       = sat_q;

  always_comb begin
    ent_n = ent_q + 32'((pg_q + 36'd16384) >> 15);
    crs_n = crs_q + 32'((pp_q + 36'd16384) >> 15);
    lnc   = 32'(ewce_pkg::LnTopQ16 - nlc);
    wm    = 48'(lnc - ent_q) * 48'(17'd32768 - 17'(ugt_q > 16'd32768 ? 16'd32768 : ugt_q));
    sum65 = {1'b0, wt_q} + {1'b0, prod_q};
    ws49  = {1'b0, ws_q} + 49'(w_q);
    r2    = {rem_q, quo_q[63]};
    rtry  = r2 - 65'(ws_q);
  end

  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      PH_IDLE: if (q_valid_i) ph_d = PH_PRD;
      PH_PRD:  ph_d = PH_MUL;
      PH_MUL:  ph_d = it_q.close_pix ? PH_W : PH_IDLE;
      PH_W:    ph_d = PH_WX;
      PH_WX:   ph_d = PH_ACC;
      PH_ACC:  ph_d = it_q.last ? PH_DIV : PH_IDLE;
      PH_DIV:  if (dcnt_q == 7'd64) ph_d = PH_OUT;
      PH_OUT:  if (out_ready_i) ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      ent_q <= '0;
      crs_q <= '0;
      ugt_q <= '0;
      wt_q  <= '0;
      ws_q  <= '0;
      dcnt_q <= '0;
    end else begin
      ph_q <= ph_d;
      unique case (ph_q)
        PH_IDLE: ;
        PH_PRD: ;
        PH_MUL: begin
          ent_q <= ent_n;
          crs_q <= crs_n;
          if (it_q.is_unknown) ugt_q <= it_q.gt;
        end
        PH_W: begin
          // weight, floored at eps
          if (lnc > ent_q) begin
            w_q <= 32'((wm + 48'd16384) >> 15);
          end else begin
            w_q <= 32'(it_q.floor_w);
          end
        end
        PH_WX: begin
          if (w_q < 32'(it_q.floor_w)) w_q <= 32'(it_q.floor_w);
          prod_q <= 64'(w_q < 32'(it_q.floor_w) ? 32'(it_q.floor_w) : w_q) * 64'(crs_q);
        end
        PH_ACC: begin
          wt_q  <= sum65[64] ? '1 : sum65[63:0];
          ws_q  <= ws49[48] ? '1 : ws49[47:0];
          ent_q <= '0;
          crs_q <= '0;
          ugt_q <= '0;
          quo_q <= sum65[64] ? '1 : sum65[63:0];
          rem_q <= '0;
          dcnt_q <= '0;
        end
        PH_DIV: begin
          if (dcnt_q < 7'd64) begin
            quo_q <= {quo_q[62:0], ~rtry[64]};
            rem_q <= rtry[64] ? r2[63:0] : rtry[63:0];
          end else begin
            // round half up: r >= d - r
            logic [64:0] qq;
            qq = {1'b0, quo_q} + 65'((ws_q != '0) && ({rem_q, 1'b0} >= 65'(ws_q)));
            if (ws_q == '0) qq = '0;
            if (qq > 65'(ewce_pkg::LossMax)) begin
              loss_q <= ewce_pkg::LossMax;
              sat_q  <= 1'b1;
            end else begin
              loss_q <= qq[23:0];
              sat_q  <= 1'b0;
            end
            wt_q <= '0;
            ws_q <= '0;
          end
          dcnt_q <= dcnt_q + 7'd1;
        end
        PH_OUT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == PH_IDLE && q_valid_i) it_q <= q_item_i;
  end

  // products registered the cycle before PH_MUL uses them
  always_ff @(posedge clk_i) begin
    if (ph_q == PH_PRD) begin
      pg_q <= 36'(it_q.gt) * 36'(nlg);
      pp_q <= 36'(it_q.gt) * 36'(nlp);
    end
  end

endmodule

>>> hw/rtl/entropy_weighted_cross_entropy_unit.sv
// ----------------------------------------------------------------------------
// entropy_weighted_cross_entropy_unit
// Entropy-weighted cross-entropy loss, forward pass, Q1.15 in, Q8.16 out.
// ----------------------------------------------------------------------------
// Items (one class of one pixel each) pass a clipping front end into a
// two-entry queue; a back end takes one item through fetch, log products
// and accumulate, and an item that closes a pixel goes on through weight,
// weighted product and accumulate. The last item adds a 64-step restoring
// divide and a rounding step before its result is shown. The back end is
// the rate limit: it takes no new item until it has finished the last one.
module entropy_weighted_cross_entropy_unit #(
  parameter int unsigned MaxClasses   = ewce_pkg::MaxClassesDef,
  parameter int unsigned LogTableBits = ewce_pkg::LogTableBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // gt_prob[15:0], pred_prob[31:16]
  input  logic        s_axis_tlast,  // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // loss_value[23:0]
  output logic        m_axis_tuser,  // saturated
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [13:0] cfg_data_i
);

  logic [6:0]  num_classes_q;
  logic [5:0]  unknown_class_q;
  logic [13:0] clip_eps_q;
  logic        qv, qr;
  ewce_pkg::ewce_item_t qi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_classes_q   <= 7'd2;
      unknown_class_q <= 6'd0;
      clip_eps_q      <= 14'd33;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ewce_pkg::CfgNumClasses:   num_classes_q   <= cfg_data_i[6:0];
        ewce_pkg::CfgUnknownClass: unknown_class_q <= cfg_data_i[5:0];
        ewce_pkg::CfgClipEps:      clip_eps_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ewce_front #(.MaxClasses(MaxClasses)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .gt_i(s_axis_tdata[15:0]), .pred_i(s_axis_tdata[31:16]), .last_i(s_axis_tlast),
    .num_classes_i(num_classes_q), .unknown_class_i(unknown_class_q),
    .clip_eps_i(clip_eps_q),
    .q_valid_o(qv), .q_ready_i(qr), .q_item_o(qi)
  );

  ewce_back #(.LogTableBits(LogTableBits)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_ready_o(qr), .q_item_i(qi),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .loss_o(m_axis_tdata), .sat_o(m_axis_tuser)
  );

endmodule

>>> hw/rtl/ewce_checker.sv
// ----------------------------------------------------------------------------
// ewce_checker
// Port-level checks on the loss unit.
// ----------------------------------------------------------------------------
module ewce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // saturated result always carries the maximum code
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'hFFFFFF) else $error("sat");

  // result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("hold");

  // one result per divide: nothing right after a taken result
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid) else $error("double");

  // a waiting input item stays valid with its last mark unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tlast))
    else $error("in hold");

endmodule

bind entropy_weighted_cross_entropy_unit ewce_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tlast,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the entropy-weighted cross-entropy unit: streams
// pixel items under random backpressure and compares each loss item with a
// bit-exact fixed-point prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [23:0] loss;
    logic        sat;
  } loss_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [13:0] cfg_data_i = '0;

  entropy_weighted_cross_entropy_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // model configuration and accumulators
  logic [31:0] ln1p_q16 [1024];
  logic [6:0]  m_classes;
  logic [5:0]  m_unknown;
  logic [13:0] m_eps;
  logic [31:0] m_cls_idx, m_entropy, m_unk_gt, m_cross;
  logic [63:0] m_wsum_loss, m_wsum;

  loss_item_t  loss_q[$];
  int          mismatches = 0;
  int          items_sent = 0;
  bit          no_idle = 1'b0;

  function automatic logic [31:0] log_entry(input int unsigned i);
    logic [63:0] m, lg;
    m  = (64'd1 << 30) + (64'(i) << 20);
    lg = '0;
    for (int b = 0; b < 20; b++) begin
      m  = (m * m) >> 30;
      lg = lg << 1;
      if (m >= (64'd1 << 31)) begin
        m     = m >> 1;
        lg[0] = 1'b1;
      end
    end
    return 32'((lg * 64'd744261118 + (64'd1 << 33)) >> 34);
  endfunction

  function automatic logic [31:0] minus_log(input logic [31:0] x);
    int unsigned k;
    logic [31:0] frac, idx, hi;
    k = 0;
    if (x == 0) x = 1;
    while (k < 15 && (x >> (k + 1)) != 0) k++;
    frac = x - (32'd1 << k);
    idx  = 32'((64'(frac) << 10) >> k) & 32'd1023;
    hi   = (15 - k) * 45426;
    return hi > ln1p_q16[idx] ? hi - ln1p_q16[idx] : 32'd0;
  endfunction

  function automatic logic [31:0] clip(input logic [31:0] v, input logic [31:0] e);
    if (v < e) return e;
    if (v > 32768 - e) return 32768 - e;
    return v;
  endfunction

  task automatic accumulate_pixel(input logic [31:0] c, input logic [31:0] e);
    logic [63:0] lnc, floor_w, w, prod, d;
    lnc     = 64'(15 * 45426) - 64'(minus_log(c));
    floor_w = 64'(e) << 1;
    w       = floor_w;
    if (lnc > 64'(m_entropy)) begin
      d = lnc - 64'(m_entropy);
      w = (d * (64'd32768 - 64'(m_unk_gt)) + 64'd16384) >> 15;
      if (w < floor_w) w = floor_w;
    end
    prod = w * 64'(m_cross);
    if (m_wsum_loss > ~64'd0 - prod) m_wsum_loss = ~64'd0;
    else m_wsum_loss += prod;
    m_wsum += w;
    if (m_wsum > 64'hFFFF_FFFF_FFFF) m_wsum = 64'hFFFF_FFFF_FFFF;
    m_cls_idx = 0;
    m_entropy = 0;
    m_unk_gt  = 0;
    m_cross   = 0;
  endtask

  task automatic predict_loss(input logic [15:0] g_in, input logic [15:0] p_in,
                              input logic last);
    logic [31:0] c, e, g, p;
    logic [63:0] q, r;
    loss_item_t  li;
    c = m_classes < 2 ? 2 : (m_classes > 64 ? 64 : m_classes);
    e = m_eps == 0 ? 1 : m_eps;
    g = clip(g_in, e);
    p = clip(p_in, e);
    m_entropy += 32'((64'(g) * minus_log(g) + 16384) >> 15);
    m_cross   += 32'((64'(g) * minus_log(p) + 16384) >> 15);
    if (m_cls_idx == 32'(m_unknown)) m_unk_gt = g;
    m_cls_idx++;
    if (m_cls_idx >= c || last) accumulate_pixel(c, e);
    if (!last) return;
    q = 0;
    if (m_wsum != 0) begin
      q = m_wsum_loss / m_wsum;
      r = m_wsum_loss % m_wsum;
      if (r >= m_wsum - r) q++;
    end
    li.sat  = q > 64'hFFFFFF;
    li.loss = li.sat ? 24'hFFFFFF : q[23:0];
    loss_q = {loss_q, li};
    m_wsum_loss = 0;
    m_wsum      = 0;
  endtask

  task automatic send_item(input logic [15:0] g, input logic [15:0] p, input logic last);
    while (!no_idle && $urandom_range(99) < 34) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {p, g};
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_loss(g, p, last);
    items_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    wait (loss_q.size() == 0);
    repeat (100) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
    drain();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      ewce_pkg::CfgNumClasses:   m_classes = val[6:0];
      ewce_pkg::CfgUnknownClass: m_unknown = val[5:0];
      ewce_pkg::CfgClipEps:      m_eps     = val;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_prob();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'd32768;
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  // one data set: npix pixels of the current class count, maybe cut short
  task automatic send_set(input int npix, input bit early);
    int c;
    c = m_classes < 2 ? 2 : (m_classes > 64 ? 64 : m_classes);
    for (int px = 0; px < npix; px++) begin
      for (int k = 0; k < c; k++) begin
        if (early && px == npix - 1 && k == c / 2) begin
          send_item(rand_prob(), rand_prob(), 1'b1);
          return;
        end
        send_item(rand_prob(), rand_prob(), px == npix - 1 && k == c - 1);
      end
    end
  endtask

  task automatic test_defaults();
    send_item(16'd32768, 16'd16384, 1'b0);
    send_item(16'd0, 16'd16384, 1'b1);
  endtask

  task automatic test_extremes();
    write_reg(ewce_pkg::CfgClipEps, 14'd1);
    send_item(16'd0, 16'd0, 1'b0);
    send_item(16'd32768, 16'd32768, 1'b1);
    write_reg(ewce_pkg::CfgClipEps, 14'd16383);
    send_item(16'd32768, 16'd0, 1'b0);
    send_item(16'd12345, 16'd32768, 1'b1);
    write_reg(ewce_pkg::CfgClipEps, 14'd0);  // acts as one
    send_item(16'd100, 16'd3, 1'b1);
    // saturation: certain truth, hopeless prediction, many classes
    write_reg(ewce_pkg::CfgClipEps, 14'd1);
    write_reg(ewce_pkg::CfgNumClasses, 14'd64);
    for (int k = 0; k < 64; k++) send_item(16'd32768, 16'd0, k == 63);
  endtask

  task automatic test_special_cases();
    write_reg(ewce_pkg::CfgNumClasses, 14'd0);  // acts as two
    write_reg(ewce_pkg::CfgUnknownClass, 14'd1);
    send_item(16'd20000, 16'd9000, 1'b0);
    send_item(16'd12768, 16'd23000, 1'b1);
    write_reg(ewce_pkg::CfgNumClasses, 14'd127);  // acts as 64
    write_reg(ewce_pkg::CfgUnknownClass, 14'd63);
    send_item(16'd500, 16'd700, 1'b0);
    send_item(16'd900, 16'd800, 1'b1);  // early last mark
    write_reg(ewce_pkg::CfgNumClasses, 14'd3);  // unknown class beyond C
    for (int k = 0; k < 3; k++) send_item(16'd10000, 16'd11000, k == 2);
    write_reg(ewce_pkg::CfgUnknownClass, 14'd0);
    write_reg(ewce_pkg::CfgClipEps, 14'd33);
  endtask

  task automatic test_random();
    int n;
    n = 0;
    while (items_sent < 1950) begin
      if ($urandom_range(5) == 0) begin
        case ($urandom_range(3))
          0: write_reg(ewce_pkg::CfgNumClasses, 14'($urandom_range(2, 8)));
          1: write_reg(ewce_pkg::CfgNumClasses, 14'($urandom_range(0, 127)));
          2: write_reg(ewce_pkg::CfgUnknownClass, 14'($urandom_range(0, 9)));
          default: write_reg(ewce_pkg::CfgClipEps, ($urandom_range(1) == 0) ?
                             14'($urandom_range(1, 64)) : 14'($urandom_range(0, 16383)));
        endcase
      end
      if (n == 20) drain();  // pause until every loss item is back
      no_idle = (n >= 40 && n < 60);
      send_set($urandom_range(1, 6), $urandom_range(9) == 0);
      n++;
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk_i)
    m_axis_tready <= no_idle || ($urandom_range(99) >= 34);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (loss_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected loss item %h", m_axis_tdata);
      end else begin
        if (m_axis_tdata !== loss_q[0].loss || m_axis_tuser !== loss_q[0].sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("loss mismatch: expected %h sat %b, got %h sat %b",
                     loss_q[0].loss, loss_q[0].sat, m_axis_tdata, m_axis_tuser);
        end
        void'(loss_q.pop_front());
      end
    end
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    for (int i = 0; i < 1024; i++) ln1p_q16[i] = log_entry(i);
    m_classes = 7'd2;
    m_unknown = 6'd0;
    m_eps     = 14'd33;
    m_cls_idx = 0;
    m_entropy = 0;
    m_unk_gt  = 0;
    m_cross   = 0;
    m_wsum_loss = 0;
    m_wsum      = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_defaults();
    test_extremes();
    test_special_cases();
    test_random();
    drain();
    if (mismatches == 0 && loss_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
